### rtl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// shared sizes, codes and helpers of the process slot table with id hash
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  localparam int unsigned NUM_SLOTS   = 256;
  localparam int unsigned NUM_BUCKETS = 64;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned PID_W  = 31;
  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned STAT_W = 2;
  // link code: one past the last slot means "none"
  localparam int unsigned LINK_W = $clog2(NUM_SLOTS + 1);
  localparam int unsigned BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned CNT_W  = LINK_W;

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_SLOTS);
  localparam logic [CNT_W-1:0]  WALK_MAX  = CNT_W'(NUM_SLOTS);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_HASH    = 3'd2,
    CMD_UNHASH  = 3'd3,
    CMD_LOOKUP  = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FREE  = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_WAIT,
    S_HASH_RD,
    S_UNH_ID,
    S_UNH_HEAD,
    S_UNH_CHK,
    S_UNH_NEXT,
    S_UNH_FIX,
    S_LK_HEAD,
    S_LK_CHK,
    S_LK_CMP,
    S_DONE
  } state_e;

  // request from the sequencer to the free list
  typedef struct packed {
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] slot;
  } fl_req_t;

  function automatic logic in_pool(input logic [LINK_W-1:0] s);
    return s < LINK_NONE;
  endfunction

  function automatic logic [BKT_W-1:0] bucket_of(input logic [PID_W-1:0] id);
    return BKT_W'(id % NUM_BUCKETS);
  endfunction

endpackage

`default_nettype wire

### rtl/pst_if.sv
// ----------------------------------------------------------------------------
// pst_cmd_if / pst_rsp_if
// valid/ready channels carrying commands in and responses out
// ----------------------------------------------------------------------------
`default_nettype none

interface pst_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [pst_pkg::CMD_W-1:0]   cmd;
  logic [pst_pkg::PID_W-1:0]   proc_id;
  logic [pst_pkg::SLOT_W-1:0]  slot;

  modport source (output valid, cmd, proc_id, slot, input ready);
  modport sink   (input valid, cmd, proc_id, slot, output ready);
endinterface

interface pst_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pst_pkg::SLOT_W-1:0]  result_slot;
  logic [pst_pkg::STAT_W-1:0]  status;

  modport source (output valid, result_slot, status, input ready);
  modport sink   (input valid, result_slot, status, output ready);
endinterface

`default_nettype wire

### rtl/pst_free_list.sv
// ----------------------------------------------------------------------------
// pst_free_list
// free slot list: head register plus next-link memory, pop and push
// ----------------------------------------------------------------------------
`default_nettype none

module pst_free_list (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pst_pkg::fl_req_t            req_i,
  output logic [pst_pkg::LINK_W-1:0]       head_o
);

  logic [pst_pkg::LINK_W-1:0] link_mem [pst_pkg::NUM_SLOTS];
  logic [pst_pkg::NUM_SLOTS-1:0] link_vld_q;

  logic [pst_pkg::LINK_W-1:0] head_q, head_d;
  logic [pst_pkg::LINK_W-1:0] rdata_q;
  logic [pst_pkg::LINK_W-1:0] raddr_q;
  logic                       rvld_q;
  logic                       pop_q;
  logic [pst_pkg::LINK_W-1:0] next_link;

  // entry never written reads as its reset link: slot i -> i+1
  assign next_link = rvld_q ? rdata_q : raddr_q + pst_pkg::LINK_W'(1);

  always_comb begin
    head_d = head_q;
    if (pop_q) begin
      head_d = next_link;
    end else if (req_i.push) begin
      head_d = pst_pkg::LINK_W'(req_i.slot);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      link_mem[req_i.slot] <= head_q;
    end
    rdata_q <= link_mem[head_q[pst_pkg::SLOT_W-1:0]];
    raddr_q <= head_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      pop_q      <= 1'b0;
      link_vld_q <= '0;
      rvld_q     <= 1'b0;
    end else begin
      head_q <= head_d;
      pop_q  <= req_i.pop;
      rvld_q <= link_vld_q[head_q[pst_pkg::SLOT_W-1:0]];
      if (req_i.push) begin
        link_vld_q[req_i.slot] <= 1'b1;
      end
    end
  end

  assign head_o = head_q;

endmodule

`default_nettype wire

### rtl/process_slot_table_with_pid_hash.sv
// ----------------------------------------------------------------------------
// process_slot_table_with_pid_hash
// slot pool with free list allocator and chained id hash (insert, unhash,
// lookup), one response per command
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                     transaction
//  cmd_i    in         cmd, proc_id, slot          valid && ready
//  rsp_o    out        result_slot, status         valid && ready
//
//  allocate pops the free list head, release pushes the slot, hash insert
//  reads the bucket head and links the slot in front, unhash reads the
//  stored id and bucket head, walks the chain and bypasses the slot, lookup
//  walks the chain comparing ids; one read of the link/id memories per step
//  reset: all buckets empty and the free list in slot order, at once
//  (valid bits), no clearing pass
//  a finished response waits in the output register; the next command is
//  taken meanwhile and stalls only when its own response is ready
//
`default_nettype none

module process_slot_table_with_pid_hash (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pst_cmd_if.sink    cmd_i,
  pst_rsp_if.source  rsp_o
);

  // --------------------------------------------------------------------------
  // storage: bucket heads (valid bits give the empty reset), chain links and
  // stored ids (undefined until written)
  // --------------------------------------------------------------------------
  logic [pst_pkg::LINK_W-1:0]      bh_mem  [pst_pkg::NUM_BUCKETS];
  logic [pst_pkg::NUM_BUCKETS-1:0] bh_vld_q;
  logic [pst_pkg::LINK_W-1:0]      cl_mem  [pst_pkg::NUM_SLOTS];
  logic [pst_pkg::PID_W-1:0]       sid_mem [pst_pkg::NUM_SLOTS];

  logic                        bh_we;
  logic [pst_pkg::BKT_W-1:0]   bh_waddr, bh_raddr;
  logic [pst_pkg::LINK_W-1:0]  bh_wdata, bh_rdata_q, bh_head;
  logic                        bh_rvld_q;

  logic                        cl_we;
  logic [pst_pkg::SLOT_W-1:0]  cl_waddr, cl_raddr;
  logic [pst_pkg::LINK_W-1:0]  cl_wdata, cl_rdata_q;

  logic                        sid_we;
  logic [pst_pkg::SLOT_W-1:0]  sid_waddr, sid_raddr;
  logic [pst_pkg::PID_W-1:0]   sid_wdata, sid_rdata_q;

  always_ff @(posedge clk_i) begin
    if (bh_we) begin
      bh_mem[bh_waddr] <= bh_wdata;
    end
    bh_rdata_q <= bh_mem[bh_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bh_vld_q  <= '0;
      bh_rvld_q <= 1'b0;
    end else begin
      bh_rvld_q <= bh_vld_q[bh_raddr];
      if (bh_we) begin
        bh_vld_q[bh_waddr] <= 1'b1;
      end
    end
  end

  // unwritten bucket reads as empty
  assign bh_head = bh_rvld_q ? bh_rdata_q : pst_pkg::LINK_NONE;

  always_ff @(posedge clk_i) begin
    if (cl_we) begin
      cl_mem[cl_waddr] <= cl_wdata;
    end
    cl_rdata_q <= cl_mem[cl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sid_we) begin
      sid_mem[sid_waddr] <= sid_wdata;
    end
    sid_rdata_q <= sid_mem[sid_raddr];
  end

  // --------------------------------------------------------------------------
  // free list
  // --------------------------------------------------------------------------
  pst_pkg::fl_req_t           fl_req;
  logic [pst_pkg::LINK_W-1:0] free_head;

  pst_free_list u_free_list (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fl_req),
    .head_o (free_head)
  );

  // --------------------------------------------------------------------------
  // command sequencer
  // --------------------------------------------------------------------------
  pst_pkg::state_e state_q, state_d;

  logic [pst_pkg::PID_W-1:0]  pid_q, pid_d;
  logic [pst_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [pst_pkg::BKT_W-1:0]  bkt_q, bkt_d;
  logic [pst_pkg::LINK_W-1:0] cur_q, cur_d;
  logic [pst_pkg::LINK_W-1:0] prev_q, prev_d;
  logic [pst_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [pst_pkg::SLOT_W-1:0] res_q, res_d;
  pst_pkg::status_e           stat_q, stat_d;

  // output register
  logic                       out_vld_q, out_vld_d;
  logic [pst_pkg::SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [pst_pkg::STAT_W-1:0] out_stat_q, out_stat_d;

  logic in_take;
  logic walk_end;

  assign cmd_i.ready = (state_q == pst_pkg::S_IDLE);
  assign in_take     = cmd_i.valid && cmd_i.ready;

  // chain walk gives up on an empty link or after a full pool of steps
  assign walk_end = !pst_pkg::in_pool(cur_q) || (cnt_q == pst_pkg::WALK_MAX);

  always_comb begin
    state_d = state_q;
    pid_d   = pid_q;
    slot_d  = slot_q;
    bkt_d   = bkt_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    stat_d  = stat_q;

    out_vld_d  = out_vld_q && !rsp_o.ready;
    out_slot_d = out_slot_q;
    out_stat_d = out_stat_q;

    fl_req = '0;

    bh_we     = 1'b0;
    bh_waddr  = bkt_q;
    bh_wdata  = pst_pkg::LINK_W'(slot_q);
    bh_raddr  = bkt_q;
    cl_we     = 1'b0;
    cl_waddr  = slot_q;
    cl_wdata  = bh_head;
    cl_raddr  = cur_q[pst_pkg::SLOT_W-1:0];
    sid_we    = 1'b0;
    sid_waddr = slot_q;
    sid_wdata = pid_q;
    sid_raddr = cur_q[pst_pkg::SLOT_W-1:0];

    case (state_q)
      pst_pkg::S_IDLE: begin
        if (in_take) begin
          pid_d  = cmd_i.proc_id;
          slot_d = cmd_i.slot;
          bkt_d  = pst_pkg::bucket_of(cmd_i.proc_id);
          res_d  = '0;
          stat_d = pst_pkg::STAT_OK;
          cnt_d  = '0;
          prev_d = pst_pkg::LINK_NONE;
          state_d = pst_pkg::S_DONE;
          case (pst_pkg::cmd_e'(cmd_i.cmd))
            pst_pkg::CMD_ALLOC: begin
              if (pst_pkg::in_pool(free_head)) begin
                res_d      = free_head[pst_pkg::SLOT_W-1:0];
                fl_req.pop = 1'b1;
                state_d    = pst_pkg::S_ALLOC_WAIT;
              end else begin
                stat_d = pst_pkg::STAT_NO_FREE;
              end
            end
            pst_pkg::CMD_RELEASE: begin
              if (pst_pkg::in_pool(pst_pkg::LINK_W'(cmd_i.slot))) begin
                fl_req.push = 1'b1;
                fl_req.slot = cmd_i.slot;
              end else begin
                stat_d = pst_pkg::STAT_NOT_FOUND;
              end
            end
            pst_pkg::CMD_HASH: begin
              if (pst_pkg::in_pool(pst_pkg::LINK_W'(cmd_i.slot))) begin
                bh_raddr = pst_pkg::bucket_of(cmd_i.proc_id);
                state_d  = pst_pkg::S_HASH_RD;
              end else begin
                stat_d = pst_pkg::STAT_NOT_FOUND;
              end
            end
            pst_pkg::CMD_UNHASH: begin
              if (pst_pkg::in_pool(pst_pkg::LINK_W'(cmd_i.slot))) begin
                sid_raddr = cmd_i.slot;
                state_d   = pst_pkg::S_UNH_ID;
              end else begin
                stat_d = pst_pkg::STAT_NOT_FOUND;
              end
            end
            pst_pkg::CMD_LOOKUP: begin
              bh_raddr = pst_pkg::bucket_of(cmd_i.proc_id);
              state_d  = pst_pkg::S_LK_HEAD;
            end
            default: begin
              // unused codes answer ok with no effect
            end
          endcase
        end
      end

      // free list head moves on at the end of this cycle
      pst_pkg::S_ALLOC_WAIT: begin
        state_d = pst_pkg::S_DONE;
      end

      // link the slot at the head of its bucket
      pst_pkg::S_HASH_RD: begin
        sid_we  = 1'b1;
        cl_we   = 1'b1;
        bh_we   = 1'b1;
        state_d = pst_pkg::S_DONE;
      end

      // stored id gives the bucket to walk
      pst_pkg::S_UNH_ID: begin
        bkt_d    = pst_pkg::bucket_of(sid_rdata_q);
        bh_raddr = pst_pkg::bucket_of(sid_rdata_q);
        state_d  = pst_pkg::S_UNH_HEAD;
      end

      pst_pkg::S_UNH_HEAD: begin
        cur_d   = bh_head;
        state_d = pst_pkg::S_UNH_CHK;
      end

      pst_pkg::S_UNH_CHK: begin
        if (walk_end) begin
          stat_d  = pst_pkg::STAT_NOT_FOUND;
          state_d = pst_pkg::S_DONE;
        end else if (cur_q == pst_pkg::LINK_W'(slot_q)) begin
          cl_raddr = slot_q;
          state_d  = pst_pkg::S_UNH_FIX;
        end else begin
          prev_d  = cur_q;
          cnt_d   = cnt_q + pst_pkg::CNT_W'(1);
          state_d = pst_pkg::S_UNH_NEXT;
        end
      end

      pst_pkg::S_UNH_NEXT: begin
        cur_d   = cl_rdata_q;
        state_d = pst_pkg::S_UNH_CHK;
      end

      // bypass the slot: predecessor or bucket head takes its link
      pst_pkg::S_UNH_FIX: begin
        if (pst_pkg::in_pool(prev_q)) begin
          cl_we    = 1'b1;
          cl_waddr = prev_q[pst_pkg::SLOT_W-1:0];
          cl_wdata = cl_rdata_q;
        end else begin
          bh_we    = 1'b1;
          bh_wdata = cl_rdata_q;
        end
        state_d = pst_pkg::S_DONE;
      end

      pst_pkg::S_LK_HEAD: begin
        cur_d   = bh_head;
        state_d = pst_pkg::S_LK_CHK;
      end

      // id and link of the current entry are read together
      pst_pkg::S_LK_CHK: begin
        if (walk_end) begin
          stat_d  = pst_pkg::STAT_NOT_FOUND;
          state_d = pst_pkg::S_DONE;
        end else begin
          state_d = pst_pkg::S_LK_CMP;
        end
      end

      pst_pkg::S_LK_CMP: begin
        if (sid_rdata_q == pid_q) begin
          res_d   = cur_q[pst_pkg::SLOT_W-1:0];
          state_d = pst_pkg::S_DONE;
        end else begin
          cur_d   = cl_rdata_q;
          cnt_d   = cnt_q + pst_pkg::CNT_W'(1);
          state_d = pst_pkg::S_LK_CHK;
        end
      end

      // hand the response over once the output register is free
      pst_pkg::S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d  = 1'b1;
          out_slot_d = res_q;
          out_stat_d = stat_q;
          state_d    = pst_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pst_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pst_pkg::S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pid_q      <= pid_d;
    slot_q     <= slot_d;
    bkt_q      <= bkt_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    stat_q     <= stat_d;
    out_slot_q <= out_slot_d;
    out_stat_q <= out_stat_d;
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.result_slot = out_slot_q;
  assign rsp_o.status      = out_stat_q;

endmodule

`default_nettype wire
